FILE: sv/rau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    // Default operand width (numerator and denominator)
    localparam int VALUE_WIDTH_DEF = 32;

    // Stream widths
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 72;

    // Input field offsets in s_axis_tdata
    localparam int OFS_MODE  = 0;
    localparam int OFS_A_NUM = 3;
    localparam int OFS_A_DEN = 35;
    localparam int OFS_B_NUM = 67;
    localparam int OFS_B_DEN = 99;

    // Operation codes
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_CMP = 3'd4;

    // Controller to datapath commands
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL1,
        CMD_MUL2,
        CMD_MUL3,
        CMD_COMB,
        CMD_GINIT,
        CMD_GSTEP,
        CMD_DSTART,
        CMD_DSTEP_N,
        CMD_DSTEP_D,
        CMD_FIN
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic have;      // operation yields a fraction to reduce
        logic gcd_done;
        logic div_done;
        logic out_full;  // output register occupied and not taken this cycle
    } t_dp_status;

endpackage

FILE: sv/rau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: loads a request, steps the multiplier, gcd and divider, and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  rau_pkg::t_dp_status i_status,
    output rau_pkg::t_cmd       o_cmd
);
    import rau_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_MUL1    = 12'b0000_0000_0010,
        S_MUL2    = 12'b0000_0000_0100,
        S_MUL3    = 12'b0000_0000_1000,
        S_COMB    = 12'b0000_0001_0000,
        S_GINIT   = 12'b0000_0010_0000,
        S_GCD     = 12'b0000_0100_0000,
        S_DNSTART = 12'b0000_1000_0000,
        S_DIVN    = 12'b0001_0000_0000,
        S_DDSTART = 12'b0010_0000_0000,
        S_DIVD    = 12'b0100_0000_0000,
        S_FIN     = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd   = CMD_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd   = CMD_MUL2;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                o_cmd   = CMD_MUL3;
                n_state = S_COMB;
            end
            S_COMB: begin
                o_cmd   = CMD_COMB;
                n_state = i_status.have ? S_GINIT : S_FIN;
            end
            S_GINIT: begin
                o_cmd   = CMD_GINIT;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (i_status.gcd_done) begin
                    n_state = S_DNSTART;
                end else begin
                    o_cmd = CMD_GSTEP;
                end
            end
            S_DNSTART: begin
                o_cmd   = CMD_DSTART;
                n_state = S_DIVN;
            end
            S_DIVN: begin
                if (i_status.div_done) begin
                    n_state = S_DDSTART;
                end else begin
                    o_cmd = CMD_DSTEP_N;
                end
            end
            S_DDSTART: begin
                o_cmd   = CMD_DSTART;
                n_state = S_DIVD;
            end
            S_DIVD: begin
                if (i_status.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd = CMD_DSTEP_D;
                end
            end
            S_FIN: begin
                if (!i_status.out_full) begin
                    o_cmd   = CMD_FIN;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/rau_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand decode, shared multiplier, sign-magnitude adder,
// binary gcd, restoring divider and the output register.
// ----------------------------------------------------------------------------
module rau_dp #(
    parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rau_pkg::t_cmd                 i_cmd,
    input  logic [rau_pkg::S_TDATA_W-1:0] i_s_data,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [rau_pkg::M_TDATA_W-1:0] o_m_data,
    output rau_pkg::t_dp_status           o_status
);
    import rau_pkg::*;

    localparam int W  = VALUE_WIDTH;
    localparam int P  = 2 * VALUE_WIDTH;
    localparam int CW = $clog2(P + 1);
    localparam logic [P-1:0] HALF = P'(1) << (W - 1);

    // Field decode: low W bits as two's complement, returned as {neg, mag}
    function automatic logic [W:0] field_val(input logic [31:0] f);
        logic [W-1:0] v;
        logic         neg;
        v   = f[W-1:0];
        neg = v[W-1];
        return {neg, neg ? (~v + W'(1)) : v};
    endfunction

    // Operand registers
    logic [2:0]   r_mode;
    logic         r_an_neg, r_bn_neg;
    logic [W-1:0] r_an_mag, r_ad_mag, r_bn_mag, r_bd_mag;
    // Products and fraction
    logic [P-1:0] r_x, r_y, r_n, r_d;
    logic         r_xneg, r_yneg, r_nneg;
    logic         r_lt, r_eq, r_gt, r_dz;
    // Gcd and divider
    logic [P-1:0] r_u, r_v, r_g, r_rem;
    logic [CW-1:0] r_k, r_cnt;
    // Output register
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;

    // Load decode
    logic [W:0]   an_f, ad_f, bn_f, bd_f;
    logic [W-1:0] ld_ad_mag, ld_bd_mag;
    logic         ld_an_neg, ld_bn_neg;

    always_comb begin
        an_f = field_val(i_s_data[OFS_A_NUM +: 32]);
        ad_f = field_val(i_s_data[OFS_A_DEN +: 32]);
        bn_f = field_val(i_s_data[OFS_B_NUM +: 32]);
        bd_f = field_val(i_s_data[OFS_B_DEN +: 32]);
        ld_ad_mag = (ad_f[W-1:0] == '0) ? W'(1) : ad_f[W-1:0];
        ld_bd_mag = (bd_f[W-1:0] == '0) ? W'(1) : bd_f[W-1:0];
        ld_an_neg = (an_f[W] ^ ad_f[W]) && (an_f[W-1:0] != '0);
        ld_bn_neg = (bn_f[W] ^ bd_f[W]) && (bn_f[W-1:0] != '0);
    end

    // Shared multiplier with operand select
    logic [W-1:0] mul_a, mul_b;
    logic [P-1:0] mul_p;
    logic         mul_neg;
    logic         is_mul;

    assign is_mul = (r_mode == MODE_MUL);

    always_comb begin
        mul_a   = r_ad_mag;
        mul_b   = r_bd_mag;
        mul_neg = 1'b0;
        case (i_cmd)
            CMD_MUL1: begin
                mul_a   = r_an_mag;
                mul_b   = is_mul ? r_bn_mag : r_bd_mag;
                mul_neg = r_an_neg ^ (is_mul & r_bn_neg);
            end
            CMD_MUL2: begin
                mul_a = r_ad_mag;
                if (is_mul) begin
                    mul_b = r_bd_mag;
                end else begin
                    mul_b   = r_bn_mag;
                    mul_neg = (r_mode != MODE_DIV) & r_bn_neg;
                end
            end
            default: ;
        endcase
        mul_p   = P'(mul_a) * P'(mul_b);
        mul_neg = mul_neg & (mul_p != '0);
    end

    // Sign-magnitude add of x and (possibly negated) y
    logic         y_neg_eff, sum_neg;
    logic [P-1:0] sum_mag;
    logic         have;

    always_comb begin
        y_neg_eff = r_yneg;
        if (r_mode == MODE_SUB || r_mode == MODE_CMP) begin
            y_neg_eff = r_yneg ^ (r_y != '0);
        end
        if (r_xneg == y_neg_eff) begin
            sum_mag = r_x + r_y;
            sum_neg = r_xneg;
        end else if (r_x >= r_y) begin
            sum_mag = r_x - r_y;
            sum_neg = r_xneg;
        end else begin
            sum_mag = r_y - r_x;
            sum_neg = y_neg_eff;
        end
        if (sum_mag == '0) begin
            sum_neg = 1'b0;
        end
        have = (r_mode == MODE_ADD) || (r_mode == MODE_SUB) || (r_mode == MODE_MUL) ||
               ((r_mode == MODE_DIV) && (r_bn_mag != '0));
    end

    // Divider step on the selected quotient register
    logic [P-1:0] dv_src, dv_rem, dv_q;
    logic [P:0]   dv_sh;

    always_comb begin
        dv_src = (i_cmd == CMD_DSTEP_D) ? r_d : r_n;
        dv_sh  = {r_rem, dv_src[P-1]};
        if (dv_sh >= {1'b0, r_g}) begin
            dv_rem = P'(dv_sh - {1'b0, r_g});
            dv_q   = {dv_src[P-2:0], 1'b1};
        end else begin
            dv_rem = dv_sh[P-1:0];
            dv_q   = {dv_src[P-2:0], 1'b0};
        end
    end

    // Result formatting
    logic                 f_zero, f_neg, f_ov, f_ok;
    logic [P-1:0]         f_den;
    logic [W-1:0]         f_nw;
    logic [31:0]          f_num32;
    logic [30:0]          f_den31;
    logic [M_TDATA_W-1:0] f_data;

    always_comb begin
        f_zero  = (r_n == '0);
        f_neg   = r_nneg & ~f_zero;
        f_den   = f_zero ? P'(1) : r_d;
        f_ov    = have && ((f_den >= HALF) || (f_neg ? (r_n > HALF) : (r_n >= HALF)));
        f_ok    = have && !f_ov;
        f_nw    = f_neg ? (~r_n[W-1:0] + W'(1)) : r_n[W-1:0];
        f_num32 = f_ok ? 32'(signed'(f_nw)) : 32'd0;
        f_den31 = f_ok ? 31'(f_den[W-2:0]) : 31'd1;
        f_data  = {4'b0, f_ov, r_dz, r_gt, r_eq, r_lt, f_den31, f_num32};
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_mode   <= i_s_data[OFS_MODE +: 3];
                r_an_mag <= an_f[W-1:0];
                r_an_neg <= ld_an_neg;
                r_ad_mag <= ld_ad_mag;
                r_bn_mag <= bn_f[W-1:0];
                r_bn_neg <= ld_bn_neg;
                r_bd_mag <= ld_bd_mag;
            end
            CMD_MUL1: begin
                r_x    <= mul_p;
                r_xneg <= mul_neg;
            end
            CMD_MUL2: begin
                r_y    <= mul_p;
                r_yneg <= mul_neg;
            end
            CMD_MUL3: begin
                r_d <= mul_p;
            end
            CMD_COMB: begin
                r_lt <= 1'b0;
                r_eq <= 1'b0;
                r_gt <= 1'b0;
                r_dz <= 1'b0;
                case (r_mode)
                    MODE_ADD, MODE_SUB: begin
                        r_n    <= sum_mag;
                        r_nneg <= sum_neg;
                    end
                    MODE_MUL: begin
                        r_n    <= r_x;
                        r_nneg <= r_xneg;
                        r_d    <= r_y;
                    end
                    MODE_DIV: begin
                        r_n    <= r_x;
                        r_nneg <= r_xneg ^ (r_bn_neg & (r_x != '0));
                        r_d    <= r_y;
                        r_dz   <= (r_bn_mag == '0);
                    end
                    MODE_CMP: begin
                        r_eq <= (sum_mag == '0);
                        r_lt <= (sum_mag != '0) & sum_neg;
                        r_gt <= (sum_mag != '0) & ~sum_neg;
                    end
                    default: ;
                endcase
            end
            CMD_GINIT: begin
                r_u <= r_d;
                r_v <= r_n;
            end
            CMD_GSTEP: begin
                if (r_u == '0 || r_v == '0) begin
                    if (r_k != '0) begin
                        r_u <= (r_u | r_v) << 1;
                        r_v <= '0;
                    end
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u >= r_v) begin
                    r_u <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            CMD_DSTART: begin
                r_g   <= r_u | r_v;
                r_rem <= '0;
            end
            CMD_DSTEP_N: begin
                r_rem <= dv_rem;
                r_n   <= dv_q;
            end
            CMD_DSTEP_D: begin
                r_rem <= dv_rem;
                r_d   <= dv_q;
            end
            CMD_FIN: begin
                r_out_data <= f_data;
            end
            default: ;
        endcase
    end

    // Counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_GINIT) begin
                r_k <= '0;
            end else if (i_cmd == CMD_GSTEP) begin
                if (r_u == '0 || r_v == '0) begin
                    if (r_k != '0) begin
                        r_k <= r_k - CW'(1);
                    end
                end else if (!r_u[0] && !r_v[0]) begin
                    r_k <= r_k + CW'(1);
                end
            end
            if (i_cmd == CMD_DSTART) begin
                r_cnt <= CW'(P);
            end else if ((i_cmd == CMD_DSTEP_N || i_cmd == CMD_DSTEP_D) && r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd == CMD_FIN) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid        = r_out_valid;
    assign o_m_data          = r_out_data;
    assign o_status.have     = have;
    assign o_status.gcd_done = (r_u == '0 || r_v == '0) && (r_k == '0);
    assign o_status.div_done = (r_cnt == '0);
    assign o_status.out_full = r_out_valid & ~i_m_tready;

endmodule

FILE: sv/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Rational ALU: add, subtract, multiply, divide or compare two fractions,
// result reduced to lowest terms with a positive denominator.
//
//  Channel  | Dir | Handshake                  | Payload
//  ---------+-----+----------------------------+------------------------------
//  s_axis   | in  | tvalid / tready            | mode, a_num, a_den, b_num, b_den
//  m_axis   | out | tvalid / tready            | result_num, result_den, flags
//
// One request at a time. Load, three multiplies on the shared multiplier and
// the combine step run in turn; reduction adds the gcd setup, the binary gcd
// (one step a cycle), two restoring divisions (start, one bit a cycle, exit)
// and the final step.
// Compare, divide by zero and unknown modes skip the reduction.
// Reset is synchronous, active low, and empties the output register.
// A stalled output register holds the finished request; the next request is
// taken meanwhile and waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
    parameter int VALUE_WIDTH = rau_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // mode[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero
    input  logic [rau_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // result_num[31:0], result_den[62:32], is_less[63], is_equal[64],
    // is_greater[65], divide_by_zero[66], overflow[67], zero
    output logic [rau_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import rau_pkg::*;

    t_cmd       cmd;
    t_dp_status status;

    rau_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    rau_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_s_data   (i_s_axis_tdata),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_data   (o_m_axis_tdata),
        .o_status   (status)
    );

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rational arithmetic unit. Requests of all
// modes go in through the input stream; each result is checked against a
// fraction reducer built into the bench, under several idling phases.
// ----------------------------------------------------------------------------
module testbench;
    import rau_pkg::*;

    localparam int W = VALUE_WIDTH_DEF;

    // laid out as the output tdata, highest field first
    typedef struct packed {
        logic        ov;
        logic        dz;
        logic        gt;
        logic        eq;
        logic        lt;
        logic [30:0] den;
        logic [31:0] num;
    } t_frac_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    t_frac_result expected_q[$];
    int           errors;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_cycles;

    rational_arithmetic_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("rational_arithmetic_unit test failed");
        $finish;
    end

    // signed value -> sign and magnitude
    function automatic void split(input logic [31:0] v, output bit neg,
                                  output logic [63:0] mag);
        neg = v[31];
        mag = neg ? 64'(-v) & 64'hFFFF_FFFF : {32'd0, v};
    endfunction

    // normalized fraction: positive nonzero denominator
    function automatic void norm_frac(input logic [31:0] n, input logic [31:0] d,
                                      output bit nneg, output logic [63:0] nmag,
                                      output logic [63:0] dmag);
        bit dneg;
        split(n, nneg, nmag);
        split(d, dneg, dmag);
        if (dmag == 0) begin
            dmag = 1;
            dneg = 0;
        end
        if (dneg) nneg = !nneg;
        if (nmag == 0) nneg = 0;
    endfunction

    // signed-magnitude sum of two 64-bit products
    function automatic void sm_add(input bit xn, input logic [63:0] xm, input bit yn,
                                   input logic [63:0] ym, output bit rn,
                                   output logic [63:0] rm);
        if (xn == yn) begin
            rm = xm + ym;
            rn = xn;
        end else if (xm >= ym) begin
            rm = xm - ym;
            rn = xn;
        end else begin
            rm = ym - xm;
            rn = yn;
        end
        if (rm == 0) rn = 0;
    endfunction

    function automatic t_frac_result reduce_fraction(input logic [2:0] mode,
            input logic [31:0] an_f, input logic [31:0] ad_f,
            input logic [31:0] bn_f, input logic [31:0] bd_f);
        t_frac_result r;
        bit           an_s, bn_s, rn_s, t_s, have;
        logic [63:0]  an, ad, bn, bd, rn, rd, t, g, x, y, z;
        r = '0;
        r.den = 1;
        have = 0;
        rn_s = 0;
        rn = 0;
        rd = 1;
        norm_frac(an_f, ad_f, an_s, an, ad);
        norm_frac(bn_f, bd_f, bn_s, bn, bd);
        case (mode)
            MODE_ADD, MODE_SUB, MODE_CMP: begin
                t = bn * ad;
                t_s = (t != 0) && (bn_s ^ (mode != MODE_ADD));
                x = an * bd;
                sm_add((x != 0) && an_s, x, t_s, t, rn_s, rn);
                if (mode == MODE_CMP) begin
                    r.eq = (rn == 0);
                    r.lt = (rn != 0) && rn_s;
                    r.gt = (rn != 0) && !rn_s;
                    rn = 0;
                end else begin
                    rd = ad * bd;
                    have = 1;
                end
            end
            MODE_MUL: begin
                rn = an * bn;
                rn_s = (rn != 0) && (an_s != bn_s);
                rd = ad * bd;
                have = 1;
            end
            MODE_DIV: begin
                if (bn == 0) r.dz = 1;
                else begin
                    rn = an * bd;
                    rn_s = (rn != 0) && (an_s != bn_s);
                    rd = ad * bn;
                    have = 1;
                end
            end
            default: ;
        endcase
        if (have) begin
            y = rd;
            z = rn;
            while (z != 0) begin
                g = y % z;
                y = z;
                z = g;
            end
            rn = rn / y;
            rd = rd / y;
            if (rn == 0) begin
                rn_s = 0;
                rd = 1;
            end
            if (rd > 64'h7FFF_FFFF || rn > (rn_s ? 64'h8000_0000 : 64'h7FFF_FFFF))
                r.ov = 1;
            else begin
                r.num = rn_s ? 32'(-rn) : rn[31:0];
                r.den = rd[30:0];
            end
        end
        return r;
    endfunction

    // one request, held until accepted; valid drops only while idling
    task automatic send_request(input logic [2:0] mode, input logic [31:0] an,
                                input logic [31:0] ad, input logic [31:0] bn,
                                input logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, bd, bn, ad, an, mode};
        expected_q.push_back(reduce_fraction(mode, an, ad, bn, bd));
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // receiver backpressure
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_frac_result got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata[67:0];
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h/%h f=%b actual %h/%h f=%b",
                             $time, want.num, want.den,
                             {want.lt, want.eq, want.gt, want.dz, want.ov},
                             got.num, got.den, {got.lt, got.eq, got.gt, got.dz, got.ov});
                    errors++;
                end
            end
        end
    end

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0: return $urandom_range(16) - 8;
            1: return $urandom_range(2000) - 1000;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0, 16'($urandom)};
            3: return 32'h8000_0000 + $urandom_range(3) - 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [2:0] m;
        for (int k = 0; k <= 7; k++) begin
            m = 3'(k);
            send_request(m, 32'sd3, 32'sd4, -32'sd5, 32'sd6);
        end
        send_request(MODE_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_request(MODE_SUB, 32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(MODE_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
        send_request(MODE_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF);
        send_request(MODE_DIV, 32'd7, 32'd3, 32'd0, 32'd5);
        send_request(MODE_DIV, 32'd6, 32'hFFFF_FFFC, 32'hFFFF_FFF7, 32'd0);
        send_request(MODE_ADD, 32'd2, 32'd3, 32'hFFFF_FFFE, 32'd3);
        send_request(MODE_CMP, 32'd1, 32'd2, 32'd2, 32'd4);
        send_request(MODE_CMP, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_request(MODE_CMP, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'd5);
        send_request(MODE_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(MODE_DIV, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
        wait_drained();
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        logic [2:0] m;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int k = 0; k < count; k++) begin
            m = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                          : 3'($urandom_range(4));
            send_request(m, rand_field(), rand_field(), rand_field(), rand_field());
        end
        wait_drained();
    endtask

    // long output stall while requests keep coming, then a drained pause
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    <= 3000;
        for (int k = 0; k < 6; k++)
            send_request(MODE_MUL, rand_field(), rand_field(), rand_field(), rand_field());
        wait_drained();
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        errors         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    <= 0;
        i_rst_n        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(500, 0, 0);
        test_random(420, 76, 0);
        test_random(420, 0, 76);
        test_random(480, 22, 22);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("rational_arithmetic_unit test passed");
        end else begin
            $display("rational_arithmetic_unit test failed");
        end
        $finish;
    end
endmodule
